// ===== rtl/hrb_pkg.sv =====
// shared types, widths, register indexes and reset values for the button remote
package hrb_pkg;

  localparam int NumButtonsDef = 6;
  localparam int TimeBitsDef   = 32;

  localparam int SampleW  = 12;
  localparam int SeqW     = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam int DebounceW = 10;
  localparam int ResendW   = 16;
  localparam int HoldW     = 20;
  localparam int IdleW     = 24;
  localparam int BatLevelW = 12;
  localparam int BatCheckW = 24;
  localparam int FlashW    = 10;
  localparam int BlinkW    = 12;

  localparam logic [DebounceW-1:0] DebounceRst = DebounceW'(10);
  localparam logic [ResendW-1:0]   ResendRst   = ResendW'(25);
  localparam logic [HoldW-1:0]     HoldRst     = HoldW'(10000);
  localparam logic [IdleW-1:0]     IdleRst     = IdleW'(30000);
  localparam logic [BatLevelW-1:0] BatLevelRst = BatLevelW'(1900);
  localparam logic [BatCheckW-1:0] BatCheckRst = BatCheckW'(60000);
  localparam logic [FlashW-1:0]    FlashRst    = FlashW'(80);
  localparam logic [BlinkW-1:0]    BlinkRst    = BlinkW'(250);

  // led level bit positions
  localparam int LedR = 0;
  localparam int LedG = 1;
  localparam int LedB = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_RESEND    = 3'd1,
    CFG_HOLD      = 3'd2,
    CFG_IDLE      = 3'd3,
    CFG_BAT_LEVEL = 3'd4,
    CFG_BAT_CHECK = 3'd5,
    CFG_FLASH     = 3'd6,
    CFG_BLINK     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_FLASH = 2'd1,
    LED_GREEN = 2'd2,
    LED_BLINK = 2'd3
  } led_mode_e;

  // per-item result flags shared by both beats of an item
  typedef struct packed {
    logic two;
    logic pkt;
    logic red;
    logic green;
    logic blue;
    logic sleep;
  } res_flags_t;

endpackage

// ===== rtl/hrb_debounce.sv =====
// per-button time debouncer producing stable pressed levels
module hrb_debounce import hrb_pkg::*; #(
  parameter int NUM_BUTTONS = NumButtonsDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [TIME_BITS-1:0]   now_i,
  input  logic [NUM_BUTTONS-1:0] raw_i,
  input  logic [DebounceW-1:0]   debounce_ms_i,
  output logic [NUM_BUTTONS-1:0] levels_o
);

  logic [NUM_BUTTONS-1:0] prev_q;
  logic [NUM_BUTTONS-1:0] stable_q, stable_d;
  logic [TIME_BITS-1:0]   stamp_q [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   stamp_d [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   elapsed [NUM_BUTTONS];

  always_comb begin
    stable_d = stable_q;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      stamp_d[i] = (raw_i[i] != prev_q[i]) ? now_i : stamp_q[i];
      elapsed[i] = now_i - stamp_d[i];
      if (32'(elapsed[i]) > 32'(debounce_ms_i)) begin
        stable_d[i] = raw_i[i];
      end
    end
  end

  assign levels_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      stable_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        stamp_q[i] <= '0;
      end
    end else if (step_i) begin
      prev_q   <= raw_i;
      stable_q <= stable_d;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        stamp_q[i] <= stamp_d[i];
      end
    end
  end

endmodule

// ===== rtl/hrb_ctrl.sv =====
// hold-to-run machine, battery check, led pattern and idle detection
module hrb_ctrl import hrb_pkg::*; #(
  parameter int NUM_BUTTONS = NumButtonsDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [TIME_BITS-1:0]   now_i,
  input  logic [NUM_BUTTONS-1:0] levels_i,
  input  logic [SampleW-1:0]     sample_i,
  input  logic [ResendW-1:0]     resend_ms_i,
  input  logic [HoldW-1:0]       hold_ms_i,
  input  logic [IdleW-1:0]       idle_ms_i,
  input  logic [BatLevelW-1:0]   bat_level_i,
  input  logic [BatCheckW-1:0]   bat_check_ms_i,
  input  logic [FlashW-1:0]      flash_ms_i,
  input  logic [BlinkW-1:0]      blink_ms_i,
  output res_flags_t             flags_o,
  output logic [NUM_BUTTONS-1:0] mask0_o,
  output logic [NUM_BUTTONS-1:0] mask1_o,
  output logic [SeqW-1:0]        seq0_o,
  output logic [SeqW-1:0]        seq1_o
);

  logic [NUM_BUTTONS-1:0] active_q, active_d;
  logic [TIME_BITS-1:0]   hold_start_q, hold_start_d;
  logic [TIME_BITS-1:0]   last_send_q, last_send_d;
  logic [TIME_BITS-1:0]   last_act_q, last_act_d;
  logic [TIME_BITS-1:0]   bat_chk_q, bat_chk_d;
  logic                   bat_low_q, bat_low_d;
  logic                   bat_seen_q;
  led_mode_e              mode_q, mode_d;
  logic [TIME_BITS-1:0]   mode_start_q, mode_start_d;
  logic [TIME_BITS-1:0]   swap_q, swap_d;
  logic                   phase_q, phase_d;
  logic [2:0]             led_q, led_d;
  logic [SeqW-1:0]        cnt_q, cnt_d;

  logic                   bat_eval;
  logic                   single;
  logic                   rep, tout;
  logic                   set_mode;
  led_mode_e              new_mode;
  logic [1:0]             npkt;
  logic                   sleep;
  logic [TIME_BITS-1:0]   el_mode, el_swap, el_send, el_hold, el_idle, el_bat;

  assign el_mode = now_i - mode_start_q;
  assign el_swap = now_i - swap_q;
  assign el_send = now_i - last_send_q;
  assign el_hold = now_i - hold_start_q;
  assign el_bat  = now_i - bat_chk_q;

  // battery check
  assign bat_eval  = !bat_seen_q || (32'(el_bat) > 32'(bat_check_ms_i));
  assign bat_low_d = bat_eval ? (sample_i < bat_level_i) : bat_low_q;
  assign bat_chk_d = bat_eval ? now_i : bat_chk_q;

  assign single = (levels_i != '0) && ((levels_i & (levels_i - NUM_BUTTONS'(1))) == '0);
  assign rep    = 32'(el_send) >= 32'(resend_ms_i);
  assign tout   = 32'(el_hold) > 32'(hold_ms_i);

  // hold-to-run
  always_comb begin
    active_d     = active_q;
    hold_start_d = hold_start_q;
    last_send_d  = last_send_q;
    last_act_d   = last_act_q;
    set_mode     = 1'b0;
    new_mode     = LED_OFF;
    npkt         = 2'd0;
    mask0_o      = '0;
    mask1_o      = '0;
    if (levels_i != '0) begin
      if (single) begin
        if (levels_i != active_q) begin
          active_d     = levels_i;
          hold_start_d = now_i;
          last_act_d   = now_i;
          last_send_d  = now_i;
          npkt         = 2'd1;
          mask0_o      = levels_i;
          set_mode     = 1'b1;
          new_mode     = bat_low_d ? LED_BLINK : LED_GREEN;
        end else begin
          if (rep) begin
            last_send_d = now_i;
            npkt        = 2'd1;
            mask0_o     = active_q;
          end
          if (tout) begin
            active_d = '0;
            npkt     = rep ? 2'd2 : 2'd1;
            set_mode = 1'b1;
          end
        end
      end else if (active_q != '0) begin
        active_d = '0;
        npkt     = 2'd1;
        set_mode = 1'b1;
      end
    end else if (active_q != '0) begin
      active_d   = '0;
      last_act_d = now_i;
      npkt       = 2'd1;
      set_mode   = 1'b1;
    end
  end

  // led update, then mode changes from the hold machine
  always_comb begin
    mode_d       = mode_q;
    mode_start_d = mode_start_q;
    swap_d       = swap_q;
    phase_d      = phase_q;
    led_d        = led_q;
    case (mode_q)
      LED_OFF: begin
        led_d = '0;
      end
      LED_FLASH: begin
        if (32'(el_mode) < 32'(flash_ms_i)) begin
          led_d = 3'(1 << LedG);
        end else begin
          mode_d = LED_OFF;
        end
      end
      LED_GREEN: begin
        led_d = 3'(1 << LedG);
      end
      LED_BLINK: begin
        if (32'(el_swap) >= 32'(blink_ms_i)) begin
          swap_d  = now_i;
          phase_d = !phase_q;
          led_d   = phase_q ? 3'(1 << LedR) : 3'(1 << LedB);
        end
      end
      default: begin
        led_d = led_q;
      end
    endcase
    if (set_mode) begin
      mode_d       = new_mode;
      mode_start_d = now_i;
      phase_d      = 1'b0;
    end
  end

  assign el_idle = now_i - last_act_d;
  assign sleep   = (active_d == '0) && (32'(el_idle) > 32'(idle_ms_i));
  assign cnt_d   = cnt_q + SeqW'(npkt);
  assign seq0_o  = cnt_q;
  assign seq1_o  = cnt_q + SeqW'(1);

  always_comb begin
    flags_o       = '0;
    flags_o.two   = (npkt == 2'd2);
    flags_o.pkt   = (npkt != 2'd0);
    flags_o.red   = led_d[LedR];
    flags_o.green = led_d[LedG];
    flags_o.blue  = led_d[LedB];
    flags_o.sleep = sleep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= '0;
      hold_start_q <= '0;
      last_send_q  <= '0;
      last_act_q   <= '0;
      bat_chk_q    <= '0;
      bat_low_q    <= 1'b0;
      bat_seen_q   <= 1'b0;
      mode_q       <= LED_OFF;
      mode_start_q <= '0;
      swap_q       <= '0;
      phase_q      <= 1'b0;
      led_q        <= '0;
      cnt_q        <= '0;
    end else if (step_i) begin
      active_q     <= active_d;
      hold_start_q <= hold_start_d;
      last_send_q  <= last_send_d;
      last_act_q   <= last_act_d;
      bat_chk_q    <= bat_chk_d;
      bat_low_q    <= bat_low_d;
      bat_seen_q   <= 1'b1;
      mode_q       <= mode_d;
      mode_start_q <= mode_start_d;
      swap_q       <= swap_d;
      phase_q      <= phase_d;
      led_q        <= led_d;
      cnt_q        <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  // at most one button is ever held
  a_active_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(active_q))
    else $error("hold mask not one-hot");

  // a second packet of an item is always a stop after a repeat
  a_two_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && flags_o.two) |-> (mask1_o == '0 && mask0_o != '0 && active_d == '0))
    else $error("two-packet item without stop");
`endif

endmodule

// ===== rtl/hrb_obuf.sv =====
// result register releasing one or two beats per item
module hrb_obuf import hrb_pkg::*; #(
  parameter int NUM_BUTTONS = NumButtonsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  res_flags_t             flags_i,
  input  logic [NUM_BUTTONS-1:0] mask0_i,
  input  logic [NUM_BUTTONS-1:0] mask1_i,
  input  logic [SeqW-1:0]        seq0_i,
  input  logic [SeqW-1:0]        seq1_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output res_flags_t             flags_o,
  output logic [NUM_BUTTONS-1:0] mask_o,
  output logic [SeqW-1:0]        seq_o,
  output logic                   last_o
);

  logic                   valid_q;
  logic                   second_q;
  res_flags_t             flags_q;
  logic [NUM_BUTTONS-1:0] mask_q, mask1_q;
  logic [SeqW-1:0]        seq_q, seq1_q;

  assign free_o = !valid_q || (ready_i && !second_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load_i) begin
      valid_q  <= 1'b1;
      second_q <= flags_i.two;
    end else if (valid_q && ready_i) begin
      valid_q  <= second_q;
      second_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_q <= flags_i;
      mask_q  <= mask0_i;
      seq_q   <= flags_i.pkt ? seq0_i : '0;
      mask1_q <= mask1_i;
      seq1_q  <= seq1_i;
    end else if (valid_q && ready_i && second_q) begin
      mask_q <= mask1_q;
      seq_q  <= seq1_q;
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign mask_o  = mask_q;
  assign seq_o   = seq_q;
  assign last_o  = !second_q;

`ifndef ASSERT_OFF
  // a pending second beat needs a held first beat
  a_second_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> valid_q)
    else $error("second beat pending without valid");

  // a non-final beat is always followed by the rest of its item
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ready_i && !last_o) |=> (valid_o && last_o))
    else $error("second beat lost");
`endif

endmodule

// ===== rtl/hold_to_run_button_remote_top.sv =====
// top level: input register, configuration registers and processing pipeline
// the input register holds an accepted beat until the result register frees and takes its result
// throughput: one item per cycle while output is ready; a stop after a repeat stalls the input
// the input register refills whenever the result register frees, back pressure is combinational
// reset: control state cleared, configuration back to defaults, ready right after reset
module hold_to_run_button_remote_top import hrb_pkg::*; #(
  parameter int NUM_BUTTONS = NumButtonsDef,
  parameter int TIME_BITS   = TimeBitsDef,
  localparam int InW        = TIME_BITS + NUM_BUTTONS + SampleW,
  localparam int InTdataW   = ((InW + 7) / 8) * 8,
  localparam int OutW       = NUM_BUTTONS + SeqW + 4,
  localparam int OutTdataW  = ((OutW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // now_ms, buttons_raw, battery_sample
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // packet_mask, packet_sequence, led_red, led_green, led_blue, sleep_request
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // packet_valid
  output logic                 m_axis_tuser_o,
  output logic                 m_axis_tlast_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic [DebounceW-1:0] debounce_q;
  logic [ResendW-1:0]   resend_q;
  logic [HoldW-1:0]     hold_q;
  logic [IdleW-1:0]     idle_q;
  logic [BatLevelW-1:0] bat_level_q;
  logic [BatCheckW-1:0] bat_check_q;
  logic [FlashW-1:0]    flash_q;
  logic [BlinkW-1:0]    blink_q;

  logic                   in_valid_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [NUM_BUTTONS-1:0] raw_q;
  logic [SampleW-1:0]     sample_q;

  logic                   res_free;
  logic                   step;
  logic [NUM_BUTTONS-1:0] levels;
  res_flags_t             flags, out_flags;
  logic [NUM_BUTTONS-1:0] mask0, mask1, out_mask;
  logic [SeqW-1:0]        seq0, seq1, out_seq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceRst;
      resend_q    <= ResendRst;
      hold_q      <= HoldRst;
      idle_q      <= IdleRst;
      bat_level_q <= BatLevelRst;
      bat_check_q <= BatCheckRst;
      flash_q     <= FlashRst;
      blink_q     <= BlinkRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE:  debounce_q  <= cfg_data_i[DebounceW-1:0];
        CFG_RESEND:    resend_q    <= cfg_data_i[ResendW-1:0];
        CFG_HOLD:      hold_q      <= cfg_data_i[HoldW-1:0];
        CFG_IDLE:      idle_q      <= cfg_data_i[IdleW-1:0];
        CFG_BAT_LEVEL: bat_level_q <= cfg_data_i[BatLevelW-1:0];
        CFG_BAT_CHECK: bat_check_q <= cfg_data_i[BatCheckW-1:0];
        CFG_FLASH:     flash_q     <= cfg_data_i[FlashW-1:0];
        CFG_BLINK:     blink_q     <= cfg_data_i[BlinkW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign step            = in_valid_q && res_free;
  assign s_axis_tready_o = !in_valid_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      now_q    <= s_axis_tdata_i[TIME_BITS-1:0];
      raw_q    <= s_axis_tdata_i[TIME_BITS +: NUM_BUTTONS];
      sample_q <= s_axis_tdata_i[TIME_BITS+NUM_BUTTONS +: SampleW];
    end
  end

  hrb_debounce #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .now_i         (now_q),
    .raw_i         (raw_q),
    .debounce_ms_i (debounce_q),
    .levels_o      (levels)
  );

  hrb_ctrl #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .now_i          (now_q),
    .levels_i       (levels),
    .sample_i       (sample_q),
    .resend_ms_i    (resend_q),
    .hold_ms_i      (hold_q),
    .idle_ms_i      (idle_q),
    .bat_level_i    (bat_level_q),
    .bat_check_ms_i (bat_check_q),
    .flash_ms_i     (flash_q),
    .blink_ms_i     (blink_q),
    .flags_o        (flags),
    .mask0_o        (mask0),
    .mask1_o        (mask1),
    .seq0_o         (seq0),
    .seq1_o         (seq1)
  );

  hrb_obuf #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .flags_i (flags),
    .mask0_i (mask0),
    .mask1_i (mask1),
    .seq0_i  (seq0),
    .seq1_i  (seq1),
    .free_o  (res_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .flags_o (out_flags),
    .mask_o  (out_mask),
    .seq_o   (out_seq),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutTdataW'({out_flags.sleep, out_flags.blue, out_flags.green,
                                      out_flags.red, out_seq, out_mask});
  assign m_axis_tuser_o = out_flags.pkt;

endmodule
